FILE: design/amr_octet_aligned_depacketizer_assert.svh
// ----------------------------------------------------------------------------
// amr depacketizer assertion macros
// shared property wrappers for the octet-aligned depacketizer
// ----------------------------------------------------------------------------
`ifndef AMR_OCTET_ALIGNED_DEPACKETIZER_ASSERT_SVH
`define AMR_OCTET_ALIGNED_DEPACKETIZER_ASSERT_SVH

// property checked on every clock edge outside reset
`define AMR_OAD_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// signal that must stay low while reset is held
`define AMR_OAD_CHECK_IN_RESET(label, sig, msg) \
    label: assert property (@(posedge clk) (!rst_n) |-> !(sig)) \
        else $error(msg);

`endif

FILE: design/amr_oad_pkg.sv
// ----------------------------------------------------------------------------
// amr_oad_pkg
// types, codes and the frame size table of the amr depacketizer
// ----------------------------------------------------------------------------
package amr_oad_pkg;

    // size of the toc store in entries
    localparam int STORE_DEPTH = 16;

    localparam logic [3:0] FT_UNSUP_LO = 4'd9;
    localparam logic [3:0] FT_UNSUP_HI = 4'd14;
    localparam int         TOC_F_BIT   = 7;

    typedef enum logic [3:0] {
        PH_CMR  = 4'b0001,
        PH_TOC  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_SKIP = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_EXEC     = 5'b00010,
        ST_ADV_RD   = 5'b00100,
        ST_ADV_EMIT = 5'b01000,
        ST_STATUS   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_UNSUPPORTED = 2'd1,
        ERR_TOO_MANY    = 2'd2,
        ERR_TRUNCATED   = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_toc;
        logic [3:0]  frame_index;
        logic [5:0]  frame_bytes;
        logic        status_valid;
        err_t        error_code;
        logic [11:0] total_samples;
        logic        last;
    } result_t;

    // data bytes per frame type, toc byte excluded
    function automatic logic [4:0] frame_octets(input logic [3:0] ft);
        logic [4:0] size;
        case (ft)
            4'd0:    size = 5'd12;
            4'd1:    size = 5'd13;
            4'd2:    size = 5'd15;
            4'd3:    size = 5'd17;
            4'd4:    size = 5'd19;
            4'd5:    size = 5'd20;
            4'd6:    size = 5'd26;
            4'd7:    size = 5'd31;
            4'd8:    size = 5'd5;
            4'd9:    size = 5'd6;
            4'd10:   size = 5'd5;
            4'd11:   size = 5'd5;
            default: size = 5'd0;
        endcase
        return size;
    endfunction

endpackage

FILE: design/amr_oad_in_if.sv
// ----------------------------------------------------------------------------
// amr_oad_in_if
// payload byte channel into the depacketizer
// ----------------------------------------------------------------------------
interface amr_oad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       packet_end;

    modport source (output valid, output in_byte, output packet_end, input ready);
    modport sink (input valid, input in_byte, input packet_end, output ready);
endinterface

FILE: design/amr_oad_out_if.sv
// ----------------------------------------------------------------------------
// amr_oad_out_if
// frame byte and status channel out of the depacketizer
// ----------------------------------------------------------------------------
interface amr_oad_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_toc;
    logic [3:0]  frame_index;
    logic [5:0]  frame_bytes;
    logic        status_valid;
    logic [1:0]  error_code;
    logic [11:0] total_samples;
    logic        last;

    modport source (
        output valid, output out_byte, output is_toc, output frame_index,
        output frame_bytes, output status_valid, output error_code,
        output total_samples, output last, input ready
    );
    modport sink (
        input valid, input out_byte, input is_toc, input frame_index,
        input frame_bytes, input status_valid, input error_code,
        input total_samples, input last, output ready
    );
endinterface

FILE: design/amr_oad_ram.sv
// ----------------------------------------------------------------------------
// amr_oad_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module amr_oad_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/amr_oad_out_stage.sv
// ----------------------------------------------------------------------------
// amr_oad_out_stage
// output register that holds one result until the sink takes it
// ----------------------------------------------------------------------------
module amr_oad_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  amr_oad_pkg::result_t  data,
    output logic                  slot_free,
    amr_oad_out_if.source         result
);

    logic                 valid_reg;
    logic                 valid_next;
    amr_oad_pkg::result_t data_reg;

    assign slot_free  = !valid_reg || result.ready;
    assign valid_next = load ? 1'b1 : (result.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result.valid         = valid_reg;
    assign result.out_byte      = data_reg.out_byte;
    assign result.is_toc        = data_reg.is_toc;
    assign result.frame_index   = data_reg.frame_index;
    assign result.frame_bytes   = data_reg.frame_bytes;
    assign result.status_valid  = data_reg.status_valid;
    assign result.error_code    = data_reg.error_code;
    assign result.total_samples = data_reg.total_samples;
    assign result.last          = data_reg.last;

endmodule

FILE: design/amr_octet_aligned_depacketizer.sv
// ----------------------------------------------------------------------------
// amr_octet_aligned_depacketizer
// splits octet-aligned amr rtp payloads into toc-prefixed frames
// ----------------------------------------------------------------------------
// channel  | modport | transaction
// payload  | sink    | one payload byte, packet_end on the final byte
// result   | source  | toc byte, frame data byte or end-of-packet status
//
// cmr, data and non-final toc bytes are each taken in idle and handled in exec
// the final toc byte and a completed frame then pass adv_rd and adv_emit per toc emitted:
//   one toc store read (registered ram output) and one output load,
//   plus a last pass through adv_rd when no frame is left to start
// the packet's last byte then passes the status state, which emits its status
// output stalls hold the sequencer; the next byte is taken while a result waits
// rst_n clears the sequencer and packet state; the toc store needs no clearing
// ----------------------------------------------------------------------------
`include "amr_octet_aligned_depacketizer_assert.svh"

module amr_octet_aligned_depacketizer #(
    parameter int MAX_FRAMES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    amr_oad_in_if.sink    payload,
    amr_oad_out_if.source result
);

    localparam int DEPTH = (MAX_FRAMES < amr_oad_pkg::STORE_DEPTH)
                           ? MAX_FRAMES : amr_oad_pkg::STORE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    amr_oad_pkg::state_t  state_reg, state_next;
    amr_oad_pkg::phase_t  phase_reg, phase_next;
    amr_oad_pkg::err_t    err_reg, err_next;
    logic [CW-1:0]        toc_count_reg, toc_count_next;
    logic [CW-1:0]        cur_frame_reg, cur_frame_next;
    logic [4:0]           bytes_left_reg, bytes_left_next;
    logic [4:0]           cur_size_reg, cur_size_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 end_reg, end_next;

    logic                 ram_we;
    logic                 ram_re;
    logic [6:0]           ram_rdata;
    logic                 load;
    logic                 slot_free;
    amr_oad_pkg::result_t res;

    logic [3:0]           ft;
    logic                 unsup;
    logic [4:0]           rd_size;
    logic [CW-1:0]        next_frame;
    logic                 more_frames;
    amr_oad_pkg::state_t  after_item;
    amr_oad_pkg::err_t    stat_err;
    logic [11:0]          samples;

    assign payload.ready = (state_reg == amr_oad_pkg::ST_IDLE);

    assign ft          = byte_reg[6:3];
    assign unsup       = (ft >= amr_oad_pkg::FT_UNSUP_LO) && (ft <= amr_oad_pkg::FT_UNSUP_HI);
    assign rd_size     = amr_oad_pkg::frame_octets(ram_rdata[6:3]);
    assign next_frame  = cur_frame_reg + CW'(1);
    assign more_frames = next_frame < toc_count_reg;
    assign after_item  = end_reg ? amr_oad_pkg::ST_STATUS : amr_oad_pkg::ST_IDLE;

    // frames * 160 as two shifted terms
    assign samples = (12'(toc_count_reg) << 7) + (12'(toc_count_reg) << 5);

    always_comb
    begin
        if (err_reg != amr_oad_pkg::ERR_NONE)
        begin
            stat_err = err_reg;
        end
        else if (phase_reg != amr_oad_pkg::PH_SKIP)
        begin
            stat_err = amr_oad_pkg::ERR_TRUNCATED;
        end
        else
        begin
            stat_err = amr_oad_pkg::ERR_NONE;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        err_next        = err_reg;
        toc_count_next  = toc_count_reg;
        cur_frame_next  = cur_frame_reg;
        bytes_left_next = bytes_left_reg;
        cur_size_next   = cur_size_reg;
        byte_next       = byte_reg;
        end_next        = end_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        load            = 1'b0;
        res             = '0;

        unique case (state_reg)
            amr_oad_pkg::ST_IDLE:
            begin
                if (payload.valid)
                begin
                    byte_next  = payload.in_byte;
                    end_next   = payload.packet_end;
                    state_next = amr_oad_pkg::ST_EXEC;
                end
            end

            amr_oad_pkg::ST_EXEC:
            begin
                unique case (phase_reg)
                    amr_oad_pkg::PH_CMR:
                    begin
                        phase_next = amr_oad_pkg::PH_TOC;
                        state_next = after_item;
                    end

                    amr_oad_pkg::PH_TOC:
                    begin
                        if (unsup)
                        begin
                            err_next   = amr_oad_pkg::ERR_UNSUPPORTED;
                            phase_next = amr_oad_pkg::PH_SKIP;
                            state_next = after_item;
                        end
                        else if (toc_count_reg == CW'(DEPTH))
                        begin
                            err_next   = amr_oad_pkg::ERR_TOO_MANY;
                            phase_next = amr_oad_pkg::PH_SKIP;
                            state_next = after_item;
                        end
                        else
                        begin
                            ram_we         = 1'b1;
                            toc_count_next = toc_count_reg + CW'(1);
                            if (!byte_reg[amr_oad_pkg::TOC_F_BIT])
                            begin
                                cur_frame_next = '0;
                                state_next     = amr_oad_pkg::ST_ADV_RD;
                            end
                            else
                            begin
                                state_next = after_item;
                            end
                        end
                    end

                    amr_oad_pkg::PH_DATA:
                    begin
                        if (slot_free)
                        begin
                            load            = 1'b1;
                            res.out_byte    = byte_reg;
                            res.frame_index = 4'(cur_frame_reg);
                            res.frame_bytes = 6'(cur_size_reg) + 6'd1;
                            // another toc follows only when this byte closes a frame
                            res.last        = !end_reg &&
                                              !((bytes_left_reg == 5'd1) && more_frames);
                            bytes_left_next = bytes_left_reg - 5'd1;
                            if (bytes_left_reg == 5'd1)
                            begin
                                cur_frame_next = next_frame;
                                state_next     = amr_oad_pkg::ST_ADV_RD;
                            end
                            else
                            begin
                                state_next = after_item;
                            end
                        end
                    end

                    amr_oad_pkg::PH_SKIP:
                    begin
                        state_next = after_item;
                    end

                    default:
                    begin
                        state_next = after_item;
                    end
                endcase
            end

            amr_oad_pkg::ST_ADV_RD:
            begin
                if (cur_frame_reg < toc_count_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = amr_oad_pkg::ST_ADV_EMIT;
                end
                else
                begin
                    phase_next = amr_oad_pkg::PH_SKIP;
                    state_next = after_item;
                end
            end

            amr_oad_pkg::ST_ADV_EMIT:
            begin
                if (slot_free)
                begin
                    load            = 1'b1;
                    res.out_byte    = {1'b0, ram_rdata};
                    res.is_toc      = 1'b1;
                    res.frame_index = 4'(cur_frame_reg);
                    res.frame_bytes = 6'(rd_size) + 6'd1;
                    res.last        = !end_reg && ((rd_size != 5'd0) || !more_frames);
                    if (rd_size != 5'd0)
                    begin
                        bytes_left_next = rd_size;
                        cur_size_next   = rd_size;
                        phase_next      = amr_oad_pkg::PH_DATA;
                        state_next      = after_item;
                    end
                    else
                    begin
                        // no-data frame: go straight on to the next toc
                        cur_frame_next = next_frame;
                        state_next     = amr_oad_pkg::ST_ADV_RD;
                    end
                end
            end

            amr_oad_pkg::ST_STATUS:
            begin
                if (slot_free)
                begin
                    load              = 1'b1;
                    res.status_valid  = 1'b1;
                    res.error_code    = stat_err;
                    res.total_samples = (stat_err == amr_oad_pkg::ERR_NONE) ? samples : 12'd0;
                    res.last          = 1'b1;
                    phase_next        = amr_oad_pkg::PH_CMR;
                    err_next          = amr_oad_pkg::ERR_NONE;
                    toc_count_next    = '0;
                    cur_frame_next    = '0;
                    bytes_left_next   = '0;
                    state_next        = amr_oad_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = amr_oad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= amr_oad_pkg::ST_IDLE;
            phase_reg      <= amr_oad_pkg::PH_CMR;
            err_reg        <= amr_oad_pkg::ERR_NONE;
            toc_count_reg  <= '0;
            cur_frame_reg  <= '0;
            bytes_left_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            err_reg        <= err_next;
            toc_count_reg  <= toc_count_next;
            cur_frame_reg  <= cur_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_size_reg <= cur_size_next;
        byte_reg     <= byte_next;
        end_reg      <= end_next;
    end

    amr_oad_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH)
    ) u_toc_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (toc_count_reg[AW-1:0]),
        .wdata (byte_reg[6:0]),
        .re    (ram_re),
        .raddr (cur_frame_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    amr_oad_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .data      (res),
        .slot_free (slot_free),
        .result    (result)
    );

    `AMR_OAD_CHECK(a_store_no_overlap, !(ram_we && ram_re), "toc store read and write in one cycle")
    `AMR_OAD_CHECK(a_frame_within_count, cur_frame_reg <= toc_count_reg, "frame index past toc count")
    `AMR_OAD_CHECK(a_count_within_depth, toc_count_reg <= CW'(DEPTH), "toc count past store depth")
    `AMR_OAD_CHECK(a_data_has_bytes, ((phase_reg == amr_oad_pkg::PH_DATA) && (state_reg != amr_oad_pkg::ST_ADV_RD) && (state_reg != amr_oad_pkg::ST_ADV_EMIT)) |-> (bytes_left_reg != 5'd0), "data phase with no bytes left")
    `AMR_OAD_CHECK(a_status_is_last, (result.valid && result.status_valid) |-> result.last, "status transaction not marked last")
    `AMR_OAD_CHECK_IN_RESET(a_quiet_in_reset, result.valid, "result valid during reset")

endmodule
